// File: src/sls_pkg.sv
// shared constants, codes and types for the sortable lifo stack
package sls_pkg;

  localparam int unsigned StackDepth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned KindW      = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned FillW      = 5;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);

  typedef logic signed [DataW-1:0] word_t;
  typedef logic [AddrW-1:0]        addr_t;
  typedef logic [CountW-1:0]       count_t;

  typedef enum logic [KindW-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_SORT = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

endpackage

// File: src/sls_mem.sv
// entry store: one write port, one read port with registered read data
module sls_mem
  import sls_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t req_i,
  output word_t    rdata_o
);

  word_t mem_q [StackDepth];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sortable_lifo_stack.sv
// top level of the sortable lifo stack: control sequencer, count and result register
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------
//   in      | input     | in_valid_i / in_ready_o | kind_i, push_value_i
//   out     | output    | out_valid_o/out_ready_i | popped_value_o, status_o, fill_count_o
//
// push, no-op, empty pop and any empty or single-entry sort finish in the accepting cycle
// pop of a non-empty stack reads the top entry from the store, then loads the result in S_POP
// sort of n entries runs n-1 bubble passes through the single memory port pair;
// each pass carries the smallest value it meets up to the pass end slot
// reset clears the count, the sequencer and the result valid flag; the store and the result payload need no clear
// intake waits while a pop or sort is in progress and while a result waits to be taken,
// unless that result is taken in the same cycle, which frees the result register for the new item
module sortable_lifo_stack
  import sls_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic        [KindW-1:0]   kind_i,
  input  logic signed [DataW-1:0]   push_value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DataW-1:0]   popped_value_o,
  output logic        [StatusW-1:0] status_o,
  output logic        [FillW-1:0]   fill_count_o
);

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_POP    = 6'b000010, // top entry read data arrives
    S_SFIRST = 6'b000100, // slot 0 arrives, becomes the carried minimum
    S_SWALK  = 6'b001000, // compare slot idx with carry, write the larger one down
    S_STAIL  = 6'b010000, // carried minimum lands on the pass end slot
    S_SDONE  = 6'b100000  // sort finished, hand out the result
  } state_e;

  state_e   state_q, state_d;
  count_t   count_q, count_d;
  word_t    carry_q, carry_d;
  addr_t    idx_q, idx_d;
  addr_t    pass_end_q, pass_end_d;

  logic         out_valid_q, out_valid_d;
  word_t        out_value_q, out_value_d;
  status_e      out_status_q, out_status_d;
  logic [FillW-1:0] out_fill_q, out_fill_d;

  mem_req_t mem_req;
  word_t    rdata;

  logic   out_free;
  logic   in_fire;
  count_t count_m1;
  kind_e  kind;

  sls_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign count_m1   = count_q - count_t'(1);
  assign kind       = kind_e'(kind_i);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    carry_d      = carry_q;
    idx_d        = idx_q;
    pass_end_d   = pass_end_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_fill_d   = out_fill_q;
    mem_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_value_d  = '0;
          out_status_d = ST_DONE;
          case (kind)
            KIND_PUSH: begin
              if (count_q == count_t'(StackDepth)) begin
                out_status_d = ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = count_q[AddrW-1:0];
                mem_req.wdata = push_value_i;
                count_d       = count_q + count_t'(1);
              end
              out_valid_d = 1'b1;
              out_fill_d  = FillW'(count_d);
            end
            KIND_POP: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
                out_valid_d  = 1'b1;
                out_fill_d   = FillW'(count_q);
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = count_m1[AddrW-1:0];
                state_d       = S_POP;
              end
            end
            KIND_SORT: begin
              if (count_q == '0) begin
                out_status_d = ST_EMPTY;
                out_valid_d  = 1'b1;
                out_fill_d   = FillW'(count_q);
              end else if (count_q == count_t'(1)) begin
                // a single entry is already in order
                out_valid_d = 1'b1;
                out_fill_d  = FillW'(count_q);
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                pass_end_d    = count_m1[AddrW-1:0];
                idx_d         = addr_t'(1);
                state_d       = S_SFIRST;
              end
            end
            default: begin
              // unused code: no-op
              out_valid_d = 1'b1;
              out_fill_d  = FillW'(count_q);
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          count_d      = count_m1;
          out_valid_d  = 1'b1;
          out_value_d  = rdata;
          out_status_d = ST_DONE;
          out_fill_d   = FillW'(count_m1);
          state_d      = S_IDLE;
        end
      end

      S_SFIRST: begin
        carry_d       = rdata;
        mem_req.re    = 1'b1;
        mem_req.raddr = idx_q;
        state_d       = S_SWALK;
      end

      S_SWALK: begin
        // larger value sinks toward the bottom, smaller one travels on
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_q - addr_t'(1);
        if (rdata > carry_q) begin
          mem_req.wdata = rdata;
        end else begin
          mem_req.wdata = carry_q;
          carry_d       = rdata;
        end
        if (idx_q == pass_end_q) begin
          state_d = S_STAIL;
        end else begin
          idx_d         = idx_q + addr_t'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = idx_q + addr_t'(1);
        end
      end

      S_STAIL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pass_end_q;
        mem_req.wdata = carry_q;
        if (pass_end_q == addr_t'(1)) begin
          state_d = S_SDONE;
        end else begin
          pass_end_d    = pass_end_q - addr_t'(1);
          idx_d         = addr_t'(1);
          mem_req.re    = 1'b1;
          mem_req.raddr = '0;
          state_d       = S_SFIRST;
        end
      end

      S_SDONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_status_d = ST_DONE;
          out_fill_d   = FillW'(count_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and walk registers need no reset
  always_ff @(posedge clk_i) begin
    carry_q      <= carry_d;
    idx_q        <= idx_d;
    pass_end_q   <= pass_end_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_fill_q   <= out_fill_d;
  end

  assign out_valid_o    = out_valid_q;
  assign popped_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign fill_count_o   = out_fill_q;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the sortable lifo stack: random push, pop and sort traffic
module tb_top;
  import sls_pkg::*;

  // the kind field can carry a code outside kind_e, the block treats it as a no-op
  localparam logic [KindW-1:0] KindNoop = 2'd3;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned TailCycles = 200;
  localparam int unsigned LongHoldCycles = 150;
  localparam int unsigned LongHoldAt = 300;

  typedef struct {
    logic [KindW-1:0] kind;
    word_t            value;
    bit               hold_for_drain;
  } stack_op_t;

  typedef struct {
    word_t              popped;
    logic [StatusW-1:0] status;
    logic [FillW-1:0]   fill;
  } stack_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KindW-1:0]   op_kind = '0;
  word_t              op_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  word_t              popped_value;
  logic [StatusW-1:0] status;
  logic [FillW-1:0]   fill_count;

  stack_op_t     op_queue[$];
  stack_result_t pending_results[$];
  int unsigned   total_ops;
  int unsigned   results_seen;
  int unsigned   quiet_cycles;
  int unsigned   hold_left;
  bit            long_hold_done;
  bit            scoreboard_failed;

  // shadow copy of the stack, slot 0 is the bottom
  word_t       shadow_words[StackDepth];
  int unsigned shadow_count;

  sortable_lifo_stack dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (op_kind),
    .push_value_i   (op_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .popped_value_o (popped_value),
    .status_o       (status),
    .fill_count_o   (fill_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one accepted item to the shadow stack and return the result it should give
  task automatic apply_to_shadow(input logic [KindW-1:0] kind, input word_t value,
                                 output stack_result_t res);
    int    i;
    int    j;
    word_t key;
    res.popped = '0;
    res.status = ST_DONE;
    case (kind)
      KIND_PUSH: begin
        if (shadow_count >= StackDepth) begin
          res.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = value;
          shadow_count++;
        end
      end
      KIND_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          shadow_count--;
          res.popped = shadow_words[shadow_count];
        end
      end
      KIND_SORT: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          // insertion sort, largest toward the bottom, signed compare
          for (i = 1; i < int'(shadow_count); i++) begin
            key = shadow_words[i];
            j = i;
            while (j > 0 && key > shadow_words[j-1]) begin
              shadow_words[j] = shadow_words[j-1];
              j--;
            end
            shadow_words[j] = key;
          end
        end
      end
      default: ;
    endcase
    res.fill = FillW'(shadow_count);
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return word_t'($signed($urandom_range(0, 6)) - 3);
      3: return $urandom_range(0, 1) ? word_t'(-1) : word_t'(0);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic void add_op(input logic [KindW-1:0] kind, input word_t value);
    stack_op_t op;
    op.kind = kind;
    op.value = value;
    op.hold_for_drain = 1'b0;
    op_queue.push_back(op);
  endfunction

  // idle percentages per phase of the run, sender first
  function automatic int unsigned idle_pct(input bit for_sender);
    int unsigned launched;
    launched = total_ops - op_queue.size();
    if (launched < total_ops / 3) return for_sender ? 34 : 82;
    if (launched < 2 * total_ops / 3) return for_sender ? 82 : 34;
    return 0;
  endfunction

  // driver: offers queued items, predicts each one at acceptance
  always @(posedge clk) begin
    stack_result_t res;
    stack_op_t     cur;
    bit            launch;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      launch = 1'b0;
      if (in_valid && in_ready) begin
        apply_to_shadow(op_kind, op_value, res);
        pending_results.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (op_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)
            && !(op_queue[0].hold_for_drain && pending_results.size() > 0)) begin
          launch = 1'b1;
        end
      end
      if (launch) begin
        cur = op_queue.pop_front();
        in_valid <= 1'b1;
        op_kind <= cur.kind;
        op_value <= cur.value;
      end else if (!in_valid || in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks every result against the oldest prediction, drives ready
  always @(posedge clk) begin
    stack_result_t exp_res;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: popped_value %0d status %0d fill_count %0d",
                 popped_value, status, fill_count);
          scoreboard_failed = 1'b1;
        end else begin
          exp_res = pending_results.pop_front();
          if (popped_value !== exp_res.popped) begin
            $error("popped_value expected %0d got %0d", exp_res.popped, popped_value);
            scoreboard_failed = 1'b1;
          end
          if (status !== exp_res.status) begin
            $error("status expected %0d got %0d", exp_res.status, status);
            scoreboard_failed = 1'b1;
          end
          if (fill_count !== exp_res.fill) begin
            $error("fill_count expected %0d got %0d", exp_res.fill, fill_count);
            scoreboard_failed = 1'b1;
          end
        end
      end
      // one long back-pressure stretch so intake backs up
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen == LongHoldAt && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_left = LongHoldCycles;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int          i;
    int          n;
    int          m;
    int unsigned r;
    // directed: empty cases, extremes, sort order, full stack
    add_op(KIND_POP, rand_word());
    add_op(KIND_SORT, rand_word());
    add_op(KindNoop, rand_word());
    add_op(KIND_PUSH, 32'sh7fff_ffff);
    add_op(KIND_PUSH, 32'sh8000_0000);
    add_op(KIND_PUSH, -32'sd1);
    add_op(KIND_PUSH, 32'sd0);
    add_op(KIND_PUSH, 32'sd1);
    add_op(KIND_SORT, 32'sh5555_5555);
    add_op(KIND_POP, 32'shaaaa_aaaa);
    for (i = 0; i < 12; i++) add_op(KIND_PUSH, rand_word());
    add_op(KIND_PUSH, rand_word());
    add_op(KIND_SORT, rand_word());
    add_op(KIND_POP, rand_word());
    // random part built from short well-formed sequences plus noise
    while (op_queue.size() < 1025) begin
      case ($urandom_range(0, 3))
        0: begin
          n = $urandom_range(1, 18);
          for (i = 0; i < n; i++) add_op(KIND_PUSH, rand_word());
          add_op(KIND_SORT, rand_word());
          m = $urandom_range(0, n);
          for (i = 0; i < m; i++) add_op(KIND_POP, rand_word());
        end
        1: begin
          for (i = 0; i < 20; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) add_op(KIND_PUSH, rand_word());
            else if (r < 80) add_op(KIND_POP, rand_word());
            else if (r < 95) add_op(KIND_SORT, rand_word());
            else add_op(KindNoop, rand_word());
          end
        end
        2: begin
          // drain past empty
          for (i = 0; i < 18; i++) add_op(KIND_POP, rand_word());
          add_op(KIND_SORT, rand_word());
        end
        default: begin
          // many duplicates
          n = $urandom_range(2, 16);
          for (i = 0; i < n; i++) add_op(KIND_PUSH, word_t'($urandom_range(0, 3)) - 2);
          add_op(KIND_SORT, rand_word());
          for (i = 0; i < n; i++) add_op(KIND_POP, rand_word());
        end
      endcase
    end
    // sender waits for the scoreboard to empty before these items
    op_queue[400].hold_for_drain = 1'b1;
    op_queue[750].hold_for_drain = 1'b1;
    total_ops = op_queue.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() > 0 || in_valid || pending_results.size() > 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (!scoreboard_failed && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
src/sls_pkg.sv
src/sls_mem.sv
src/sortable_lifo_stack.sv
tb/tb_top.sv
